FILE: rtl/rfccs_pkg.sv
`timescale 1ns / 1ps

package rfccs_pkg;

	localparam int CLK_W = 31;

	localparam logic [25:0] RATE_LO = 26'd520833;
	localparam logic [25:0] RATE_HI = 26'd61440000;

	localparam logic [31:0] LIM_FIR_IN = 32'd122880000;
	localparam logic [31:0] LIM_HB1_IN = 32'd245760000;
	localparam logic [31:0] LIM_HB2_IN = 32'd320000000;

	localparam logic [CLK_W-1:0] MIN_CONV_HZ = 31'd25000000;
	localparam logic [CLK_W-1:0] MAX_ADC_HZ  = 31'd640000000;
	localparam logic [CLK_W-1:0] MAX_DAC_HZ  = 31'd320000000;

	localparam logic [37:0] PLL_LO_HZ = 38'd714928500;
	localparam logic [37:0] PLL_HI_HZ = 38'd1430143000;

	localparam logic [1:0] LAST_FIR       = 2'd2;
	localparam logic [2:0] LAST_SET       = 3'd6;
	localparam logic [2:0] DIV2_SET_LIMIT = 3'd5;
	localparam logic [2:0] LAST_MUL       = 3'd5;
	localparam logic [2:0] MAX_PLL_SHIFT  = 3'd6;
	localparam logic [2:0] LAST_STAGE     = 3'd5;

	localparam logic [2:0] STAGE_PLL  = 3'd0;
	localparam logic [2:0] STAGE_CONV = 3'd1;
	localparam logic [2:0] STAGE_HB3  = 3'd2;
	localparam logic [2:0] STAGE_HB2  = 3'd3;
	localparam logic [2:0] STAGE_HB1  = 3'd4;

	// half-band factor codes
	localparam logic [1:0] HB_X1 = 2'd1;
	localparam logic [1:0] HB_X2 = 2'd2;
	localparam logic [1:0] HB_X3 = 2'd3;

	typedef enum logic [3:0] {
		S_IDLE,
		S_RANGE,
		S_CALC,
		S_TEST,
		S_PLL,
		S_DIV,
		S_ADV,
		S_EMIT,
		S_FAIL
	} state_t;

	typedef struct packed {
		logic       load;
		logic       clear_best;
		logic       calc;
		logic       pll_try;
		logic       commit;
		logic       emit;
		logic       emit_fail;
		logic [1:0] fir_idx;
		logic [2:0] set_idx;
		logic [2:0] mul_idx;
		logic [2:0] stage;
	} cmd_t;

	typedef struct packed {
		logic range_ok;
		logic set_ok;
		logic pll_hit;
		logic found;
	} status_t;

	// sets in scan order: (3,2,2) (2,2,2) (3,2,1) (2,2,1) (2,1,1) (3,1,1) (1,1,1)
	function automatic logic [1:0] set_hb3(input logic [2:0] s);
		case (s)
			3'd0, 3'd2, 3'd5: set_hb3 = HB_X3;
			3'd1, 3'd3, 3'd4: set_hb3 = HB_X2;
			default:          set_hb3 = HB_X1;
		endcase
	endfunction

	function automatic logic [1:0] set_hb2(input logic [2:0] s);
		case (s)
			3'd0, 3'd1, 3'd2, 3'd3: set_hb2 = HB_X2;
			default:                set_hb2 = HB_X1;
		endcase
	endfunction

	function automatic logic [1:0] set_hb1(input logic [2:0] s);
		case (s)
			3'd0, 3'd1: set_hb1 = HB_X2;
			default:    set_hb1 = HB_X1;
		endcase
	endfunction

	function automatic logic [31:0] hb_scale(input logic [31:0] x, input logic [1:0] f);
		case (f)
			HB_X2:   hb_scale = x << 1;
			HB_X3:   hb_scale = x + (x << 1);
			default: hb_scale = x;
		endcase
	endfunction

endpackage

FILE: rtl/rfccs_ctrl.sv
`timescale 1ns / 1ps

module rfccs_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  rfccs_pkg::status_t status,
	output rfccs_pkg::cmd_t    cmd
);

	rfccs_pkg::state_t state_q, state_d;
	logic [1:0] fir_q;
	logic [2:0] set_q;
	logic [2:0] mul_q;
	logic [2:0] stage_q;

	assign busy = (state_q != rfccs_pkg::S_IDLE);

	always_comb begin
		state_d = state_q;
		case (state_q)
			rfccs_pkg::S_IDLE: begin
				if (start)
					state_d = rfccs_pkg::S_RANGE;
			end
			rfccs_pkg::S_RANGE: begin
				state_d = status.range_ok ? rfccs_pkg::S_CALC : rfccs_pkg::S_FAIL;
			end
			rfccs_pkg::S_CALC: state_d = rfccs_pkg::S_TEST;
			rfccs_pkg::S_TEST: begin
				state_d = status.set_ok ? rfccs_pkg::S_PLL : rfccs_pkg::S_ADV;
			end
			rfccs_pkg::S_PLL: begin
				if (status.pll_hit)
					state_d = rfccs_pkg::S_DIV;
				else if (mul_q == rfccs_pkg::LAST_MUL)
					state_d = rfccs_pkg::S_ADV;
			end
			rfccs_pkg::S_DIV: state_d = rfccs_pkg::S_ADV;
			rfccs_pkg::S_ADV: begin
				if (set_q != rfccs_pkg::LAST_SET)
					state_d = rfccs_pkg::S_CALC;
				else if (status.found)
					state_d = rfccs_pkg::S_EMIT;
				else if (fir_q == rfccs_pkg::LAST_FIR)
					state_d = rfccs_pkg::S_FAIL;
				else
					state_d = rfccs_pkg::S_CALC;
			end
			rfccs_pkg::S_EMIT: begin
				if (stage_q == rfccs_pkg::LAST_STAGE)
					state_d = rfccs_pkg::S_IDLE;
			end
			rfccs_pkg::S_FAIL: state_d = rfccs_pkg::S_IDLE;
			default:           state_d = rfccs_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		cmd         = '0;
		cmd.fir_idx = fir_q;
		cmd.set_idx = set_q;
		cmd.mul_idx = mul_q;
		cmd.stage   = stage_q;
		case (state_q)
			rfccs_pkg::S_IDLE:  cmd.load = start;
			rfccs_pkg::S_RANGE: cmd.clear_best = 1'b1;
			rfccs_pkg::S_CALC:  cmd.calc = 1'b1;
			rfccs_pkg::S_PLL:   cmd.pll_try = 1'b1;
			rfccs_pkg::S_DIV:   cmd.commit = 1'b1;
			rfccs_pkg::S_ADV: begin
				cmd.clear_best = (set_q == rfccs_pkg::LAST_SET) && !status.found &&
					(fir_q != rfccs_pkg::LAST_FIR);
			end
			rfccs_pkg::S_EMIT:  cmd.emit = 1'b1;
			rfccs_pkg::S_FAIL:  cmd.emit_fail = 1'b1;
			default:            cmd = cmd;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rfccs_pkg::S_IDLE;
			fir_q   <= '0;
			set_q   <= '0;
			mul_q   <= '0;
			stage_q <= '0;
		end else begin
			state_q <= state_d;
			case (state_q)
				rfccs_pkg::S_RANGE: begin
					fir_q   <= '0;
					set_q   <= '0;
					stage_q <= '0;
				end
				rfccs_pkg::S_TEST: mul_q <= '0;
				rfccs_pkg::S_PLL: begin
					if (!status.pll_hit && mul_q != rfccs_pkg::LAST_MUL)
						mul_q <= mul_q + 3'd1;
				end
				rfccs_pkg::S_ADV: begin
					if (set_q != rfccs_pkg::LAST_SET) begin
						set_q <= set_q + 3'd1;
					end else if (!status.found && fir_q != rfccs_pkg::LAST_FIR) begin
						fir_q <= fir_q + 2'd1;
						set_q <= '0;
					end
				end
				rfccs_pkg::S_EMIT: stage_q <= stage_q + 3'd1;
				default: stage_q <= stage_q;
			endcase
		end
	end

endmodule

FILE: rtl/rfccs_dp.sv
`timescale 1ns / 1ps

module rfccs_dp (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic                          cfg_wdata,
	input  logic [25:0]                   wanted_sample_rate,
	input  rfccs_pkg::cmd_t               cmd,
	output rfccs_pkg::status_t            status,
	output logic                          result_valid,
	output logic [2:0]                    stage_index,
	output logic [rfccs_pkg::CLK_W-1:0]   rx_clock,
	output logic [rfccs_pkg::CLK_W-1:0]   tx_clock,
	output logic                          failed,
	output logic                          last
);

	localparam int W = rfccs_pkg::CLK_W;

	logic        gov_q;
	logic [25:0] rate_q;

	logic [31:0] c4, c3, c2, c1;
	logic [1:0]  fir_sh;
	logic [1:0]  hb3;
	logic        chain_ok;

	logic [W-1:0] r4_q, r3_q, r2_q, r1_q, r0_q;
	logic         set_ok_q;

	logic [2:0]  pll_sh;
	logic [37:0] pll_prod;
	logic        pll_hit;

	logic [W-1:0] half;
	logic         div1, div2, better;

	logic [W-1:0] best_r0_q, best_r1_q, best_r2_q, best_r3_q, best_r4_q;
	logic [2:0]   best_set_q;
	logic         best_div2_q;
	logic         found_q;

	logic [W-1:0] sel_rx;
	logic         halve;

	logic         valid_q;
	logic [2:0]   stage_q;
	logic [W-1:0] rx_q, tx_q;
	logic         failed_q, last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			gov_q <= 1'b0;
		else if (cfg_we)
			gov_q <= cfg_wdata;
	end

	always_ff @(posedge clk) begin
		if (cmd.load)
			rate_q <= wanted_sample_rate;
	end

	assign fir_sh = 2'd2 - cmd.fir_idx;
	assign hb3    = rfccs_pkg::set_hb3(cmd.set_idx);

	always_comb begin
		c4 = {6'd0, rate_q} << fir_sh;
		c3 = rfccs_pkg::hb_scale(c4, rfccs_pkg::set_hb1(cmd.set_idx));
		c2 = rfccs_pkg::hb_scale(c3, rfccs_pkg::set_hb2(cmd.set_idx));
		c1 = rfccs_pkg::hb_scale(c2, hb3);
		chain_ok = (c4 <= rfccs_pkg::LIM_FIR_IN) && (c3 <= rfccs_pkg::LIM_HB1_IN) &&
			(c2 <= rfccs_pkg::LIM_HB2_IN) && !(gov_q && hb3 == rfccs_pkg::HB_X3);
	end

	always_ff @(posedge clk) begin
		if (cmd.calc) begin
			r4_q     <= c4[W-1:0];
			r3_q     <= c3[W-1:0];
			r2_q     <= c2[W-1:0];
			r1_q     <= c1[W-1:0];
			set_ok_q <= chain_ok;
		end
	end

	// multiplier 64 down to 2
	assign pll_sh   = rfccs_pkg::MAX_PLL_SHIFT - cmd.mul_idx;
	assign pll_prod = {7'd0, r1_q} << pll_sh;
	assign pll_hit  = (pll_prod >= rfccs_pkg::PLL_LO_HZ) && (pll_prod <= rfccs_pkg::PLL_HI_HZ);

	always_ff @(posedge clk) begin
		if (cmd.pll_try && pll_hit)
			r0_q <= pll_prod[W-1:0];
	end

	assign half   = r1_q >> 1;
	assign div1   = (r1_q >= rfccs_pkg::MIN_CONV_HZ) && (r1_q <= rfccs_pkg::MAX_DAC_HZ);
	assign div2   = (r1_q >= rfccs_pkg::MIN_CONV_HZ) && (r1_q <= rfccs_pkg::MAX_ADC_HZ) &&
		(half >= rfccs_pkg::MIN_CONV_HZ) && (half <= rfccs_pkg::MAX_DAC_HZ) &&
		(cmd.set_idx < rfccs_pkg::DIV2_SET_LIMIT);
	assign better = !found_q || (r1_q > best_r1_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			found_q <= 1'b0;
		else if (cmd.clear_best)
			found_q <= 1'b0;
		else if (cmd.commit && (div1 || div2) && better)
			found_q <= 1'b1;
	end

	always_ff @(posedge clk) begin
		if (cmd.commit && (div1 || div2) && better) begin
			best_r0_q   <= r0_q;
			best_r1_q   <= r1_q;
			best_r2_q   <= r2_q;
			best_r3_q   <= r3_q;
			best_r4_q   <= r4_q;
			best_set_q  <= cmd.set_idx;
			best_div2_q <= !div1;
		end
	end

	always_comb begin
		case (cmd.stage)
			rfccs_pkg::STAGE_PLL:  sel_rx = best_r0_q;
			rfccs_pkg::STAGE_CONV: sel_rx = best_r1_q;
			rfccs_pkg::STAGE_HB3:  sel_rx = best_r2_q;
			rfccs_pkg::STAGE_HB2:  sel_rx = best_r3_q;
			rfccs_pkg::STAGE_HB1:  sel_rx = best_r4_q;
			default:               sel_rx = {5'd0, rate_q};
		endcase
		halve = best_div2_q && (cmd.stage != rfccs_pkg::STAGE_PLL) &&
			((best_set_q inside {[3'd0:3'd1]} && cmd.stage <= rfccs_pkg::STAGE_HB2) ||
			 (best_set_q inside {[3'd2:3'd3]} && cmd.stage <= rfccs_pkg::STAGE_HB3));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_q <= 1'b0;
		else
			valid_q <= cmd.emit || cmd.emit_fail;
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			stage_q  <= cmd.stage;
			rx_q     <= sel_rx;
			tx_q     <= halve ? (sel_rx >> 1) : sel_rx;
			failed_q <= 1'b0;
			last_q   <= (cmd.stage == rfccs_pkg::LAST_STAGE);
		end else if (cmd.emit_fail) begin
			stage_q  <= rfccs_pkg::STAGE_PLL;
			rx_q     <= '0;
			tx_q     <= '0;
			failed_q <= 1'b1;
			last_q   <= 1'b1;
		end
	end

	assign status.range_ok = (rate_q >= rfccs_pkg::RATE_LO) && (rate_q <= rfccs_pkg::RATE_HI);
	assign status.set_ok   = set_ok_q;
	assign status.pll_hit  = pll_hit;
	assign status.found    = found_q;

	assign result_valid = valid_q;
	assign stage_index  = stage_q;
	assign rx_clock     = rx_q;
	assign tx_clock     = tx_q;
	assign failed       = failed_q;
	assign last         = last_q;

endmodule

FILE: rtl/rf_clock_chain_search.sv
`timescale 1ns / 1ps

// Clock chain search for the receive and transmit paths.
// Request: pulse start with wanted_sample_rate while busy is low; that edge
// takes the transaction and busy rises on the next cycle.
// Configuration: cfg_we with cfg_wdata writes rate_governor_on; write only
// while busy is low.
// Results: each result sits on stage_index, rx_clock, tx_clock, failed and
// last for one cycle, marked by result_valid. A good chain gives six results
// on consecutive cycles, PLL first, last set on the sample rate. A rate out
// of range or no usable chain gives one result with failed and last set.
// Search: each candidate set is evaluated and tested; a set that passes
// runs the PLL multiplier search (up to six multipliers, one multiplier a
// cycle), then a divider step if a multiplier hits; every set ends with a
// step to the next. 21 sets worst case. One transaction at a time; busy
// falls as the last result shows, so the next transaction can be taken in
// that cycle.
// The receiver cannot stall.
// Reset: asynchronous, clears the controller, result strobe and the
// governor register (off).

module rf_clock_chain_search (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [25:0] wanted_sample_rate,
	input  logic        cfg_we,
	input  logic        cfg_wdata,
	output logic        result_valid,
	output logic [2:0]  stage_index,
	output logic [30:0] rx_clock,
	output logic [30:0] tx_clock,
	output logic        failed,
	output logic        last
);

	rfccs_pkg::cmd_t    cmd;
	rfccs_pkg::status_t status;

	rfccs_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.status (status),
		.cmd    (cmd)
	);

	rfccs_dp u_dp (
		.clk                (clk),
		.arst_n             (arst_n),
		.cfg_we             (cfg_we),
		.cfg_wdata          (cfg_wdata),
		.wanted_sample_rate (wanted_sample_rate),
		.cmd                (cmd),
		.status             (status),
		.result_valid       (result_valid),
		.stage_index        (stage_index),
		.rx_clock           (rx_clock),
		.tx_clock           (tx_clock),
		.failed             (failed),
		.last               (last)
	);

endmodule

FILE: rtl/rfccs_chk.sv
`timescale 1ns / 1ps

module rfccs_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input logic        result_valid,
	input logic [2:0]  stage_index,
	input logic [30:0] rx_clock,
	input logic [30:0] tx_clock,
	input logic        failed,
	input logic        last
);

	a_fail_form: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && failed |-> last && stage_index == 3'd0 &&
			rx_clock == 31'd0 && tx_clock == 31'd0)
		else $error("error result malformed");

	a_stage_run: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !last |=> result_valid && !failed &&
			stage_index == $past(stage_index) + 3'd1)
		else $error("result run broken");

	a_tx_le_rx: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !failed |-> tx_clock <= rx_clock)
		else $error("tx clock above rx clock");

	a_take_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("busy not raised after transaction taken");

endmodule

bind rf_clock_chain_search rfccs_chk u_rfccs_chk (
	.clk          (clk),
	.arst_n       (arst_n),
	.start        (start),
	.busy         (busy),
	.result_valid (result_valid),
	.stage_index  (stage_index),
	.rx_clock     (rx_clock),
	.tx_clock     (tx_clock),
	.failed       (failed),
	.last         (last)
);

FILE: tb/rf_clock_chain_search_tb.sv
`timescale 1ns / 1ps

module rf_clock_chain_search_tb;

	localparam longint unsigned RATE_MIN   = 25000000 / 48;
	localparam longint unsigned RATE_MAX   = 61440000;
	localparam longint unsigned FIR_IN_MAX = 122880000;
	localparam longint unsigned HB1_IN_MAX = 245760000;
	localparam longint unsigned HB2_IN_MAX = 320000000;
	localparam longint unsigned CONV_MIN   = 25000000;
	localparam longint unsigned ADC_MAX    = 640000000;
	localparam longint unsigned DAC_MAX    = 320000000;
	localparam longint unsigned PLL_MIN    = 714928500;
	localparam longint unsigned PLL_MAX    = 1430143000;

	localparam int DIR_ROWS       = 12;
	localparam int RAND_PHASES    = 4;
	localparam int RAND_PER_PHASE = 75;
	localparam int SETTLE_CYCLES  = 300;

	typedef struct packed {
		logic [2:0]  stage;
		logic [30:0] rx;
		logic [30:0] tx;
		logic        failed;
		logic        last;
	} stage_result_t;

	typedef struct packed {
		logic        reject;
		logic [25:0] rate;
	} rate_row_t;

	localparam stage_result_t REJECTED = {rfccs_pkg::STAGE_PLL, 31'd0, 31'd0, 1'b1, 1'b1};

	// reject=1: a single failed result is expected, typed in here
	rate_row_t dir_rows [DIR_ROWS] = '{
		{1'b1, 26'd0},
		{1'b1, 26'd520832},
		{1'b0, 26'd520833},
		{1'b0, 26'd520834},
		{1'b0, 26'd1000000},
		{1'b0, 26'd3000000},
		{1'b0, 26'd7680000},
		{1'b0, 26'd25000000},
		{1'b0, 26'd30720000},
		{1'b0, 26'd61440000},
		{1'b1, 26'd61440001},
		{1'b1, 26'd67108863}
	};

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	logic [25:0] wanted_sample_rate = '0;
	logic        cfg_we = 1'b0;
	logic        cfg_wdata = 1'b0;
	logic        result_valid;
	logic [2:0]  stage_index;
	logic [30:0] rx_clock;
	logic [30:0] tx_clock;
	logic        failed;
	logic        last;

	stage_result_t stage_q [$];
	stage_result_t want;
	bit            gov_on = 1'b0;
	int            mismatches = 0;
	int            requests = 0;
	int            chains = 0;
	int            rejects = 0;
	int            results_seen = 0;

	always #2 clk = ~clk;

	rf_clock_chain_search i_dut (
		.clk               (clk),
		.arst_n            (arst_n),
		.start             (start),
		.busy              (busy),
		.wanted_sample_rate(wanted_sample_rate),
		.cfg_we            (cfg_we),
		.cfg_wdata         (cfg_wdata),
		.result_valid      (result_valid),
		.stage_index       (stage_index),
		.rx_clock          (rx_clock),
		.tx_clock          (tx_clock),
		.failed            (failed),
		.last              (last)
	);

	// chain search: FIR 4,2,1 in turn, seven half-band sets each
	function automatic void predict_chain(input logic [25:0] rate);
		longint unsigned fir, best, dac_div;
		longint unsigned r [6];
		longint unsigned rx_best [6];
		longint unsigned tx_best [6];
		int unsigned     h3, h2, h1;
		stage_result_t   res;
		int              f, s, k, m;
		best = 0;
		if (rate >= RATE_MIN && rate <= RATE_MAX) begin
			for (f = 0; f < 3 && best == 0; f++) begin
				fir = 64'd4 >> f;
				for (s = 0; s < 7; s++) begin
					case (s)
						0: {h3, h2, h1} = {32'd3, 32'd2, 32'd2};
						1: {h3, h2, h1} = {32'd2, 32'd2, 32'd2};
						2: {h3, h2, h1} = {32'd3, 32'd2, 32'd1};
						3: {h3, h2, h1} = {32'd2, 32'd2, 32'd1};
						4: {h3, h2, h1} = {32'd2, 32'd1, 32'd1};
						5: {h3, h2, h1} = {32'd3, 32'd1, 32'd1};
						default: {h3, h2, h1} = {32'd1, 32'd1, 32'd1};
					endcase
					if (gov_on && h3 == 3)
						continue;
					r[5] = 64'(rate);
					r[4] = r[5] * fir;
					r[3] = r[4] * h1;
					r[2] = r[3] * h2;
					r[1] = r[2] * h3;
					if (r[4] > FIR_IN_MAX || r[3] > HB1_IN_MAX || r[2] > HB2_IN_MAX)
						continue;
					r[0] = 0;
					for (m = 6; m >= 1; m--) begin
						if ((r[1] << m) >= PLL_MIN && (r[1] << m) <= PLL_MAX) begin
							r[0] = r[1] << m;
							break;
						end
					end
					if (r[0] == 0)
						continue;
					if (r[1] >= CONV_MIN && r[1] <= DAC_MAX)
						dac_div = 1;
					else if (r[1] >= CONV_MIN && r[1] <= ADC_MAX && r[1] / 2 >= CONV_MIN &&
							r[1] / 2 <= DAC_MAX && s < 5)
						dac_div = 2;
					else
						continue;
					if (r[1] <= best)
						continue;
					best = r[1];
					for (k = 0; k < 6; k++) begin
						rx_best[k] = r[k];
						tx_best[k] = r[k];
						if (k > 0 && ((s < 2 && k < 4) || (s >= 2 && s < 4 && k < 3)))
							tx_best[k] = r[k] / dac_div;
					end
				end
			end
		end
		if (best == 0) begin
			stage_q.push_back(REJECTED);
			rejects++;
		end else begin
			for (k = 0; k < 6; k++) begin
				res.stage  = 3'(k);
				res.rx     = 31'(rx_best[k]);
				res.tx     = 31'(tx_best[k]);
				res.failed = 1'b0;
				res.last   = (k == 5);
				stage_q.push_back(res);
			end
			chains++;
		end
	endfunction

	function automatic void cmp_field(input string name, input longint unsigned exp_v,
			input logic [63:0] act_v);
		if (act_v !== exp_v) begin
			$display("%0t: %s expected %0d, got %0d", $time, name, exp_v, act_v);
			mismatches++;
		end
	endfunction

	function automatic int gap_len();
		int r;
		r = $urandom_range(99, 0);
		if (r < 50)
			return 0;
		if (r < 85)
			return $urandom_range(3, 1);
		if (r < 97)
			return $urandom_range(12, 4);
		return $urandom_range(150, 30);
	endfunction

	function automatic logic [25:0] pick_rate();
		int unsigned r;
		int unsigned div_by;
		bit [31:0]   raw;
		logic [25:0] v;
		r = $urandom_range(99, 0);
		if (r < 10) begin
			raw = $urandom();
			v = raw[25:0];
		end else if (r < 15) begin
			v = 26'($urandom_range(32'(RATE_MIN + 3000), 32'(RATE_MIN - 3)));
		end else if (r < 20) begin
			v = 26'($urandom_range(32'(RATE_MAX + 3), 32'(RATE_MAX - 3000)));
		end else if (r < 35) begin
			// standard rates and their neighbours
			div_by = $urandom_range(2, 0) * 2 + 1;
			v = 26'((RATE_MAX / div_by) >> $urandom_range(6, 0));
			v = v + 26'($urandom_range(2, 0)) - 26'd1;
		end else if (r < 60) begin
			v = 26'($urandom_range(32'(RATE_MAX), 32'(RATE_MIN)) >> $urandom_range(5, 0));
		end else begin
			v = 26'($urandom_range(32'(RATE_MAX), 32'(RATE_MIN)));
		end
		return v;
	endfunction

	// called at a falling edge; returns at the falling edge after acceptance
	task automatic send_rate(input logic [25:0] rate, input logic reject, input int gap);
		if (gap > 0) begin
			start = 1'b0;
			repeat (gap) @(negedge clk);
		end
		wanted_sample_rate = rate;
		start = 1'b1;
		do @(posedge clk); while (busy !== 1'b0);
		requests++;
		if (reject) begin
			stage_q.push_back(REJECTED);
			rejects++;
		end else begin
			predict_chain(rate);
		end
		@(negedge clk);
	endtask

	task automatic drain_results();
		start = 1'b0;
		while (stage_q.size() != 0 || busy !== 1'b0)
			@(negedge clk);
	endtask

	task automatic set_governor(input bit on);
		drain_results();
		cfg_wdata = on;
		cfg_we = 1'b1;
		@(negedge clk);
		cfg_we = 1'b0;
		gov_on = on;
	endtask

	always @(posedge clk) begin
		if (arst_n && $isunknown(result_valid)) begin
			$display("%0t: result_valid expected 0 or 1, got %b", $time, result_valid);
			mismatches++;
		end else if (arst_n && result_valid) begin
			results_seen++;
			if (stage_q.size() == 0) begin
				$display("%0t: no result expected, got stage %0d rx %0d tx %0d failed %b last %b",
					$time, stage_index, rx_clock, tx_clock, failed, last);
				mismatches++;
			end else begin
				want = stage_q.pop_front();
				cmp_field("stage_index", 64'(want.stage), 64'(stage_index));
				cmp_field("rx_clock", 64'(want.rx), 64'(rx_clock));
				cmp_field("tx_clock", 64'(want.tx), 64'(tx_clock));
				cmp_field("failed", 64'(want.failed), 64'(failed));
				cmp_field("last", 64'(want.last), 64'(last));
			end
		end
	end

	initial begin
		int p, i;
		repeat (2) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		for (p = 0; p < 2; p++) begin
			if (p == 1)
				set_governor(1'b1);
			for (i = 0; i < DIR_ROWS; i++)
				send_rate(dir_rows[i].rate, dir_rows[i].reject, gap_len());
		end
		for (p = 0; p < RAND_PHASES; p++) begin
			set_governor(p[0]);
			for (i = 0; i < RAND_PER_PHASE; i++) begin
				if (i == RAND_PER_PHASE / 2)
					drain_results();
				send_rate(pick_rate(), 1'b0, (i >= 10 && i < 30) ? 0 : gap_len());
			end
		end
		drain_results();
		repeat (SETTLE_CYCLES) @(negedge clk);
		$display("%0d requests with governor off and on: %0d chains found, %0d rejected",
			requests, chains, rejects);
		$display("%0d stage results checked, %0d mismatches", results_seen, mismatches);
		if (mismatches == 0)
			$display("rf_clock_chain_search_tb: clean");
		else
			$display("rf_clock_chain_search_tb: errors");
		$finish;
	end

	initial begin
		#2000000;
		$display("timeout with %0d results outstanding", stage_q.size());
		$display("rf_clock_chain_search_tb: errors");
		$finish;
	end

endmodule
